>>> rtl/ps2sc_pkg.sv
// Package: shared types, scan code constants and key maps for the scan code translator.
`default_nettype none
package ps2sc_pkg;

	localparam logic [7:0] SC_EXT_PREFIX = 8'hE0;
	localparam logic [6:0] KEY_LSHIFT    = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT    = 7'h36;
	localparam logic [6:0] KEY_CTRL      = 7'h1D;
	localparam logic [6:0] KEY_ALT       = 7'h38;
	localparam logic [6:0] KEY_CAPS      = 7'h3A;
	localparam logic [6:0] KEY_UP        = 7'h48;
	localparam logic [6:0] KEY_DOWN      = 7'h50;
	localparam logic [6:0] KEY_LEFT      = 7'h4B;
	localparam logic [6:0] KEY_RIGHT     = 7'h4D;

	localparam logic [6:0] CHR_ESC       = 7'h1B;
	localparam logic [6:0] CHR_BRACKET   = 7'h5B;
	localparam logic [6:0] CHR_A         = 7'h41;
	localparam logic [6:0] CHR_B         = 7'h42;
	localparam logic [6:0] CHR_C         = 7'h43;
	localparam logic [6:0] CHR_D         = 7'h44;
	localparam logic [6:0] CASE_BIT      = 7'h20;

	// modifier bit positions
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_LCTRL  = 2;
	localparam int MOD_RCTRL  = 3;
	localparam int MOD_LALT   = 4;
	localparam int MOD_RALT   = 5;

	localparam int ARROW_LAST = 2;

	typedef struct packed {
		logic shift;
		logic ctrl;
		logic alt;
		logic caps;
	} flags_t;

	typedef struct packed {
		logic       arrow;
		logic [6:0] chr;
		flags_t     flags;
	} run_t;

	// only the lower 64 codes map to anything
	localparam logic [6:0] PLAIN_MAP [64] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] SHIFT_MAP [64] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

endpackage
`default_nettype wire

>>> rtl/ps2sc_if.sv
// Interfaces: scan code input channel and character output channel.
`default_nettype none
interface ps2sc_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] scancode;

	modport source (output valid, output scancode, input ready);
	modport sink (input valid, input scancode, output ready);
endinterface

interface ps2sc_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last_of_run;
	logic       shift_held;
	logic       ctrl_held;
	logic       alt_held;
	logic       caps_on;

	modport source (
		output valid, output character, output last_of_run, output shift_held,
		output ctrl_held, output alt_held, output caps_on, input ready
	);
	modport sink (
		input valid, input character, input last_of_run, input shift_held,
		input ctrl_held, input alt_held, input caps_on, output ready
	);
endinterface
`default_nettype wire

>>> rtl/ps2sc_decode.sv
// Decoder: prefix, modifier and caps lock state, and key lookup for one scan code.
`default_nettype none
module ps2sc_decode
	import ps2sc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] scancode,
	input  wire logic       accept,
	output run_t            run,
	output logic            run_valid
);

	logic       ext_q;
	logic [5:0] mods_q;
	logic       caps_q;

	logic       ext_d;
	logic [5:0] mods_d;
	logic       caps_d;
	logic       down;
	logic [6:0] key;
	logic [6:0] base_chr;
	logic [6:0] chr;

	assign down = ~scancode[7];
	assign key  = scancode[6:0];

	always_comb begin
		ext_d     = ext_q;
		mods_d    = mods_q;
		caps_d    = caps_q;
		run_valid = 1'b0;
		run.arrow = 1'b0;
		run.chr   = '0;
		run.flags.shift = mods_q[MOD_LSHIFT] | mods_q[MOD_RSHIFT];
		run.flags.ctrl  = mods_q[MOD_LCTRL] | mods_q[MOD_RCTRL];
		run.flags.alt   = mods_q[MOD_LALT] | mods_q[MOD_RALT];
		run.flags.caps  = caps_q;

		if (key[6]) begin
			base_chr = '0;
		end else if (run.flags.shift && PLAIN_MAP[key[5:0]] != '0) begin
			base_chr = SHIFT_MAP[key[5:0]];
		end else begin
			base_chr = PLAIN_MAP[key[5:0]];
		end
		chr = base_chr;
		if (caps_q && (base_chr inside {[7'h61:7'h7A], [7'h41:7'h5A]})) begin
			chr = base_chr ^ CASE_BIT;
		end

		if (scancode == SC_EXT_PREFIX) begin
			ext_d = 1'b1;
		end else if (ext_q) begin
			ext_d = 1'b0;
			case (key)
				KEY_CTRL:  mods_d[MOD_RCTRL] = down;
				KEY_ALT:   mods_d[MOD_RALT]  = down;
				KEY_UP: begin
					run_valid = down;
					run.arrow = 1'b1;
					run.chr   = CHR_A;
				end
				KEY_DOWN: begin
					run_valid = down;
					run.arrow = 1'b1;
					run.chr   = CHR_B;
				end
				KEY_RIGHT: begin
					run_valid = down;
					run.arrow = 1'b1;
					run.chr   = CHR_C;
				end
				KEY_LEFT: begin
					run_valid = down;
					run.arrow = 1'b1;
					run.chr   = CHR_D;
				end
				default: ;
			endcase
		end else begin
			case (key)
				KEY_LSHIFT: mods_d[MOD_LSHIFT] = down;
				KEY_RSHIFT: mods_d[MOD_RSHIFT] = down;
				KEY_CTRL:   mods_d[MOD_LCTRL]  = down;
				KEY_ALT:    mods_d[MOD_LALT]   = down;
				KEY_CAPS:   caps_d = caps_q ^ down;
				default: begin
					run_valid = down && (chr != '0);
					run.chr   = chr;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= 1'b0;
			mods_q <= '0;
			caps_q <= 1'b0;
		end else if (accept) begin
			ext_q  <= ext_d;
			mods_q <= mods_d;
			caps_q <= caps_d;
		end
	end

`ifndef SYNTHESIS
	a_prefix_sets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scancode == SC_EXT_PREFIX |=> ext_q)
		else $error("prefix flag not set after prefix byte");
	a_prefix_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scancode != SC_EXT_PREFIX |=> !ext_q)
		else $error("prefix flag survived a non-prefix byte");
	a_arrow_needs_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run.arrow |-> ext_q && down)
		else $error("arrow run without prefixed press");
`endif

endmodule
`default_nettype wire

>>> rtl/ps2sc_emit.sv
// Emitter: holds a run and sends its words one per cycle unless stalled.
`default_nettype none
module ps2sc_emit
	import ps2sc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  run_t        run,
	output logic        take,
	ps2sc_char_if.source chars
);

	run_t       run_q;
	logic       valid_q;
	logic [1:0] idx_q;
	logic       last;
	logic       fire;

	assign last  = !run_q.arrow || idx_q == 2'(ARROW_LAST);
	assign fire  = valid_q && chars.ready;
	assign take  = !valid_q || (fire && last);

	always_comb begin
		if (!run_q.arrow) begin
			chars.character = run_q.chr;
		end else begin
			case (idx_q)
				2'd0:    chars.character = CHR_ESC;
				2'd1:    chars.character = CHR_BRACKET;
				default: chars.character = run_q.chr;
			endcase
		end
	end

	assign chars.valid       = valid_q;
	assign chars.last_of_run = last;
	assign chars.shift_held  = run_q.flags.shift;
	assign chars.ctrl_held   = run_q.flags.ctrl;
	assign chars.alt_held    = run_q.flags.alt;
	assign chars.caps_on     = run_q.flags.caps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (fire) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q != 2'd3)
		else $error("run index out of range");
	a_single_idx: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !run_q.arrow |-> idx_q == 2'd0)
		else $error("single-character run advanced");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !last |=> valid_q && idx_q == $past(idx_q) + 2'd1)
		else $error("arrow run did not advance");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last && !load |=> !valid_q)
		else $error("run not released after last word");
`endif

endmodule
`default_nettype wire

>>> rtl/ps2_scancode_to_ascii.sv
// Top level: set-1 scan code to ASCII translator.
//
//  channel | dir | word
//  keys    | in  | scancode[7:0]
//  chars   | out | character[6:0], last_of_run, shift/ctrl/alt/caps flags
//
// A scan code is decoded in the cycle it is taken; its characters leave from the
// run register, one word per cycle while chars is ready: one for a plain key, three
// for an arrow. Codes that give no character load no run, but wait while a run is held.
// keys.ready is high while the run register is empty or its last word leaves.
// A stall on chars holds the current word and run; reset clears all state but run data.
`default_nettype none
module ps2_scancode_to_ascii
	import ps2sc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	ps2sc_code_if.sink   keys,
	ps2sc_char_if.source chars
);

	run_t run;
	logic run_valid;
	logic take;
	logic accept;

	assign keys.ready = take;
	assign accept     = keys.valid && take;

	ps2sc_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.scancode  (keys.scancode),
		.accept    (accept),
		.run       (run),
		.run_valid (run_valid)
	);

	ps2sc_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && run_valid),
		.run    (run),
		.take   (take),
		.chars  (chars)
	);

endmodule
`default_nettype wire
